>>> hdl/sn_pkg.sv
// shared types, constants and helper functions for the simplex noise block
`timescale 1ns / 1ps

package sn_pkg;

    localparam int TBL_AW = 8;
    localparam int AMP_W  = 35;
    localparam int TERM_W = 48;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_NOISE   = 2'd1;
    localparam logic [1:0] CMD_FRACTAL = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [2:0] REG_FREQUENCY  = 3'd0;
    localparam logic [2:0] REG_OUT_MIN    = 3'd1;
    localparam logic [2:0] REG_OUT_MAX    = 3'd2;
    localparam logic [2:0] REG_OCTAVES    = 3'd3;
    localparam logic [2:0] REG_LACUNARITY = 3'd4;
    localparam logic [2:0] REG_GAIN       = 3'd5;

    localparam logic signed [15:0] SKEW_F2   = 16'sd23988;
    localparam logic signed [15:0] UNSKEW_G2 = 16'sd13849;
    localparam logic signed [47:0] D_ONE     = 48'sd65536;
    localparam logic signed [47:0] D_G2      = 48'sd13849;
    localparam logic signed [47:0] D_G2X2    = 48'sd27698;
    localparam logic signed [21:0] T_HALF    = 22'sd32768;
    localparam logic signed [AMP_W-1:0] AMP_LIMIT = 35'sd8589934592;

    typedef struct packed {
        logic                    valid;
        logic                    load;
        logic                    noise;
        logic                    first;
        logic                    last;
        logic [TBL_AW-1:0]       eidx;
        logic [7:0]              evalue;
        logic signed [AMP_W-1:0] amp;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [23:0]        f;
    } t_pass;

    // value mod 12 via reciprocal multiply, exact for 8-bit values
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = v * 8'd171;
        q = p[15:11];
        r = v - 8'(q * 4'd12);
        return r[3:0];
    endfunction

    function automatic logic signed [19:0] grad_dot(input logic [3:0] g,
                                                    input logic signed [17:0] dx,
                                                    input logic signed [17:0] dy);
        logic signed [19:0] ex;
        logic signed [19:0] ey;
        ex = 20'(dx);
        ey = 20'(dy);
        case (g)
            4'd0: grad_dot = ex + ey;
            4'd1: grad_dot = ey - ex;
            4'd2: grad_dot = ex - ey;
            4'd3: grad_dot = -ex - ey;
            4'd4, 4'd6: grad_dot = ex;
            4'd5, 4'd7: grad_dot = -ex;
            4'd8, 4'd10: grad_dot = ey;
            4'd9, 4'd11: grad_dot = -ey;
            default: grad_dot = '0;
        endcase
    endfunction

    // offsets this large always give a negative falloff, so clamping is safe
    function automatic logic signed [17:0] clamp_d(input logic signed [47:0] v);
        if (v > 48'sd131071) begin
            return 18'sd131071;
        end else if (v < -48'sd131072) begin
            return -18'sd131072;
        end
        return v[17:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > 52'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

>>> hdl/sn_perm_ram.sv
// one copy of the permutation table, one write and one registered read port
`timescale 1ns / 1ps

module sn_perm_ram (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [sn_pkg::TBL_AW-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [sn_pkg::TBL_AW-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [2**sn_pkg::TBL_AW];
    logic [7:0] r_rdata;

    // read returns the old entry when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sn_seq.sv
// octave sequencer: turns items into pipeline passes, one per cycle while enabled
`timescale 1ns / 1ps

module sn_seq #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_in_valid,
    input  logic [1:0]                       i_command,
    input  logic signed [31:0]               i_coord_x,
    input  logic signed [31:0]               i_coord_y,
    input  logic [7:0]                       i_entry_index,
    input  logic [7:0]                       i_entry_value,
    input  logic [23:0]                      i_frequency,
    input  logic signed [32:0]               i_diff,
    input  logic [3:0]                       i_octave_count,
    input  logic [15:0]                      i_lacunarity,
    input  logic [15:0]                      i_gain,
    output logic                             o_in_stall,
    output sn_pkg::t_pass                    o_pass
);

    localparam int LW = $clog2(MAX_OCTAVES + 1);

    logic                             r_busy;
    logic [LW-1:0]                    r_left;
    logic [23:0]                      r_f;
    logic signed [sn_pkg::AMP_W-1:0]  r_a;
    logic signed [31:0]               r_cx;
    logic signed [31:0]               r_cy;
    logic [LW-1:0]                    n_left;
    logic [LW-1:0]                    w_n;
    logic                             w_accept;
    logic [23:0]                      w_f;
    logic signed [sn_pkg::AMP_W-1:0]  w_a;
    logic [39:0]                      w_fp;
    logic [27:0]                      w_fs;
    logic [23:0]                      w_fn;
    logic signed [51:0]               w_ap;
    logic signed [39:0]               w_as;
    logic signed [sn_pkg::AMP_W-1:0]  w_an;

    assign w_n = LW'((int'(i_octave_count) > MAX_OCTAVES) ? MAX_OCTAVES
                                                          : int'(i_octave_count));
    assign w_accept = i_en && i_in_valid && !r_busy;
    assign o_in_stall = !i_en || r_busy;

    always_comb begin
        o_pass        = '0;
        o_pass.tag.eidx   = i_entry_index;
        o_pass.tag.evalue = i_entry_value;
        if (r_busy) begin
            w_f = r_f;
            w_a = r_a;
            o_pass.tag.valid = 1'b1;
            o_pass.tag.last  = (r_left == LW'(1));
            o_pass.cx = r_cx;
            o_pass.cy = r_cy;
        end else begin
            w_f = i_frequency;
            // fractal with zero octaves runs one pass at zero amplitude
            w_a = (i_command == sn_pkg::CMD_FRACTAL && w_n == '0) ? '0
                                                                  : sn_pkg::AMP_W'(i_diff);
            o_pass.tag.valid = i_in_valid && (i_command != sn_pkg::CMD_NONE);
            o_pass.tag.load  = (i_command == sn_pkg::CMD_LOAD);
            o_pass.tag.noise = (i_command == sn_pkg::CMD_NOISE);
            o_pass.tag.first = 1'b1;
            o_pass.tag.last  = (i_command != sn_pkg::CMD_FRACTAL) || (w_n <= LW'(1));
            o_pass.cx = i_coord_x;
            o_pass.cy = i_coord_y;
        end
        o_pass.f       = w_f;
        o_pass.tag.amp = w_a;
    end

    // next octave frequency and amplitude
    always_comb begin
        w_fp = w_f * i_lacunarity;
        w_fs = w_fp[39:12];
        w_fn = (|w_fs[27:24]) ? 24'hffffff : w_fs[23:0];
        w_ap = w_a * $signed({1'b0, i_gain});
        w_as = w_ap[51:12];
        if (w_as > 40'(sn_pkg::AMP_LIMIT)) begin
            w_an = sn_pkg::AMP_LIMIT;
        end else if (w_as < -40'(sn_pkg::AMP_LIMIT)) begin
            w_an = -sn_pkg::AMP_LIMIT;
        end else begin
            w_an = w_as[sn_pkg::AMP_W-1:0];
        end
    end

    assign n_left = r_busy ? r_left - LW'(1) : w_n - LW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (r_busy && i_en) begin
            r_left <= n_left;
            if (r_left == LW'(1)) begin
                r_busy <= 1'b0;
            end
        end else if (w_accept && i_command == sn_pkg::CMD_FRACTAL && w_n > LW'(1)) begin
            r_busy <= 1'b1;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && (r_busy || w_accept)) begin
            r_f <= w_fn;
            r_a <= w_an;
        end
        if (w_accept) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
    end

endmodule

>>> hdl/sn_core.sv
// eleven-stage noise pipeline: skew, cell, corners, table hashing, falloff, scale
`timescale 1ns / 1ps

module sn_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  sn_pkg::t_pass                     i_pass,
    output sn_pkg::t_tag                      o_tag,
    output logic signed [sn_pkg::TERM_W-1:0]  o_term
);

    localparam int NST = 11;

    sn_pkg::t_tag r_tag [1:NST];

    logic signed [40:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic signed [41:0] r_s2;
    logic signed [27:0] r_i3, r_j3;
    logic signed [45:0] r_x0_4, r_y0_4;
    logic [7:0]         r_ii4, r_jj4, r_ii5;
    logic               r_i1_5;
    logic signed [17:0] r_d5 [6];
    logic signed [17:0] r_d6 [6];
    logic signed [21:0] r_t6 [3];
    logic signed [19:0] r_dot7 [3];
    logic signed [19:0] r_dot8 [3];
    logic [14:0]        r_t2_7 [3];
    logic [13:0]        r_t4_8 [3];
    logic signed [18:0] r_c9 [3];
    logic signed [28:0] r_u10;
    logic signed [sn_pkg::TERM_W-1:0] r_term11;

    function automatic logic signed [27:0] cell_floor(input logic signed [42:0] v);
        logic signed [43:0] nv;
        nv = -44'(v);
        if (v > 43'sd0) begin
            return 28'(v[42:16]);
        end
        return ~nv[43:16];
    endfunction

    logic signed [56:0] w_px, w_py;
    logic signed [41:0] w_xy;
    logic signed [57:0] w_sp;
    logic signed [42:0] w_vx, w_vy;
    logic signed [28:0] w_ij;
    logic signed [43:0] w_t;
    logic signed [45:0] w_x0, w_y0;
    logic               w_i1;
    logic signed [47:0] w_off [6];
    logic [7:0]         w_ra [3];
    logic [7:0]         w_rb [3];
    logic [7:0]         w_pa [3];
    logic [7:0]         w_pb [3];
    logic               w_we;

    // stage 1: scale by frequency
    assign w_px = i_pass.cx * $signed({1'b0, i_pass.f});
    assign w_py = i_pass.cy * $signed({1'b0, i_pass.f});
    // stage 2: skew
    assign w_xy = 42'(r_x1) + 42'(r_y1);
    assign w_sp = w_xy * sn_pkg::SKEW_F2;
    // stage 3: cell
    assign w_vx = 43'(r_x2) + 43'(r_s2);
    assign w_vy = 43'(r_y2) + 43'(r_s2);
    // stage 4: unskew to first corner offset
    assign w_ij = 29'(r_i3) + 29'(r_j3);
    assign w_t  = w_ij * sn_pkg::UNSKEW_G2;
    assign w_x0 = 46'(r_x3) - 46'($signed({r_i3, 16'h0})) + 46'(w_t);
    assign w_y0 = 46'(r_y3) - 46'($signed({r_j3, 16'h0})) + 46'(w_t);
    // stage 5: middle corner choice and offsets, first table reads
    assign w_i1 = (r_x0_4 > r_y0_4);
    assign w_off[0] = 48'(r_x0_4);
    assign w_off[1] = 48'(r_y0_4);
    assign w_off[2] = 48'(r_x0_4) - (w_i1 ? sn_pkg::D_ONE : 48'sd0) + sn_pkg::D_G2;
    assign w_off[3] = 48'(r_y0_4) - (w_i1 ? 48'sd0 : sn_pkg::D_ONE) + sn_pkg::D_G2;
    assign w_off[4] = 48'(r_x0_4) - sn_pkg::D_ONE + sn_pkg::D_G2X2;
    assign w_off[5] = 48'(r_y0_4) - sn_pkg::D_ONE + sn_pkg::D_G2X2;
    assign w_ra[0] = r_jj4;
    assign w_ra[1] = r_jj4 + {7'h0, ~w_i1};
    assign w_ra[2] = r_jj4 + 8'd1;
    // stage 6: second table reads
    assign w_rb[0] = r_ii5 + w_pa[0];
    assign w_rb[1] = r_ii5 + {7'h0, r_i1_5} + w_pa[1];
    assign w_rb[2] = r_ii5 + 8'd1 + w_pa[2];

    // table loads land here so earlier items still see the old entries
    assign w_we = i_en && r_tag[4].valid && r_tag[4].load;

    for (genvar c = 0; c < 3; c++) begin : g_ram
        sn_perm_ram u_ram_a (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_we    (w_we),
            .i_waddr (r_tag[4].eidx),
            .i_wdata (r_tag[4].evalue),
            .i_raddr (w_ra[c]),
            .o_rdata (w_pa[c])
        );
        sn_perm_ram u_ram_b (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_we    (w_we),
            .i_waddr (r_tag[4].eidx),
            .i_wdata (r_tag[4].evalue),
            .i_raddr (w_rb[c]),
            .o_rdata (w_pb[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NST; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            r_tag[1] <= i_pass.tag;
            for (int k = 2; k <= NST; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [35:0] sqx;
        logic [35:0] sqy;
        logic [33:0] sqt;
        logic [29:0] sq2;
        logic signed [34:0] pc;
        logic signed [20:0] sum;
        logic signed [29:0] v70;
        logic signed [63:0] pt;
        if (i_en) begin
            r_x1 <= w_px[56:16];
            r_y1 <= w_py[56:16];

            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r_s2 <= w_sp[57:16];

            r_x3 <= r_x2;
            r_y3 <= r_y2;
            r_i3 <= cell_floor(w_vx);
            r_j3 <= cell_floor(w_vy);

            r_x0_4 <= w_x0;
            r_y0_4 <= w_y0;
            r_ii4  <= r_i3[7:0];
            r_jj4  <= r_j3[7:0];

            r_i1_5 <= w_i1;
            r_ii5  <= r_ii4;
            for (int k = 0; k < 6; k++) begin
                r_d5[k] <= sn_pkg::clamp_d(w_off[k]);
                r_d6[k] <= r_d5[k];
            end

            for (int c = 0; c < 3; c++) begin
                sqx = 36'($signed(r_d5[2*c]) * $signed(r_d5[2*c]));
                sqy = 36'($signed(r_d5[2*c+1]) * $signed(r_d5[2*c+1]));
                r_t6[c] <= sn_pkg::T_HALF - $signed({2'b00, sqx[35:16]})
                                         - $signed({2'b00, sqy[35:16]});

                // a negative falloff becomes zero weight
                sqt = r_t6[c][16:0] * r_t6[c][16:0];
                r_t2_7[c] <= r_t6[c][21] ? 15'h0 : sqt[30:16];
                r_dot7[c] <= sn_pkg::grad_dot(sn_pkg::mod12(w_pb[c]),
                                              r_d6[2*c], r_d6[2*c+1]);

                sq2 = r_t2_7[c] * r_t2_7[c];
                r_t4_8[c] <= sq2[29:16];
                r_dot8[c] <= r_dot7[c];

                pc = $signed({1'b0, r_t4_8[c]}) * r_dot8[c];
                r_c9[c] <= pc[34:16];
            end

            sum = 21'(r_c9[0]) + 21'(r_c9[1]) + 21'(r_c9[2]);
            v70 = 30'(sum) * 30'sd70 + 30'sd65536;
            r_u10 <= v70[29:1];

            pt = r_tag[10].amp * r_u10;
            r_term11 <= pt[63:16];
        end
    end

    assign o_tag  = r_tag[NST];
    assign o_term = r_term11;

endmodule

>>> hdl/simplex_noise_2d.sv
// top level: configuration registers, sequencer, noise pipeline, octave accumulator
`timescale 1ns / 1ps

// Two-dimensional simplex noise in signed Q16.16. Load, noise and unused commands
// are taken one per cycle while the output is not stalled; a fractal item holds
// the input until its last pass is issued, with octaves capped at MAX_OCTAVES, as
// the octave sequencer issues one pass per cycle into the noise pipeline while the
// output is not stalled. Each pass goes through eleven register stages and then the
// octave accumulator, whose output register holds the result. The permutation table
// holds whatever was loaded and must be filled before noise is asked for; it is
// not cleared at reset.
module simplex_noise_2d #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic [7:0]         i_entry_index,
    input  logic [7:0]         i_entry_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_noise_value,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [23:0]        r_frequency;
    logic signed [31:0] r_out_min;
    logic signed [31:0] r_out_max;
    logic [3:0]         r_octave_count;
    logic [15:0]        r_lacunarity;
    logic [15:0]        r_gain;
    logic               r_out_valid;
    logic signed [31:0] r_out;
    logic signed [51:0] r_acc;
    logic signed [51:0] n_acc;
    logic signed [51:0] w_base;
    logic signed [32:0] w_diff;
    logic               w_en;

    sn_pkg::t_pass                    w_pass;
    sn_pkg::t_tag                     w_tag;
    logic signed [sn_pkg::TERM_W-1:0] w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frequency    <= 24'd65536;
            r_out_min      <= 32'sd0;
            r_out_max      <= 32'sd65536;
            r_octave_count <= 4'd1;
            r_lacunarity   <= 16'd8192;
            r_gain         <= 16'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sn_pkg::REG_FREQUENCY:  r_frequency    <= i_cfg_data[23:0];
                sn_pkg::REG_OUT_MIN:    r_out_min      <= i_cfg_data;
                sn_pkg::REG_OUT_MAX:    r_out_max      <= i_cfg_data;
                sn_pkg::REG_OCTAVES:    r_octave_count <= i_cfg_data[3:0];
                sn_pkg::REG_LACUNARITY: r_lacunarity   <= i_cfg_data[15:0];
                sn_pkg::REG_GAIN:       r_gain         <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_diff = 33'(r_out_max) - 33'(r_out_min);

    // the whole pipeline moves unless a result is held back at the output
    assign w_en = !r_out_valid || !i_out_stall;

    sn_seq #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_in_valid     (i_in_valid),
        .i_command      (i_command),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_frequency    (r_frequency),
        .i_diff         (w_diff),
        .i_octave_count (r_octave_count),
        .i_lacunarity   (r_lacunarity),
        .i_gain         (r_gain),
        .o_in_stall     (o_in_stall),
        .o_pass         (w_pass)
    );

    sn_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_pass  (w_pass),
        .o_tag   (w_tag),
        .o_term  (w_term)
    );

    // single noise starts from the range floor, fractal sums from zero
    always_comb begin
        if (w_tag.first) begin
            w_base = w_tag.noise ? 52'(r_out_min) : 52'sd0;
        end else begin
            w_base = r_acc;
        end
        n_acc = w_base + 52'(w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tag.valid && !w_tag.load && w_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tag.valid && !w_tag.load) begin
            r_acc <= n_acc;
            if (w_tag.last) begin
                r_out <= sn_pkg::sat32(n_acc);
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out;

endmodule
